>>> src/sacd_pkg.sv
// shared types and constants for the set associative cache directory
// no dependencies
package sacd_pkg;

    localparam int OP_BITS = 2;
    localparam int POLICY_BITS = 2;
    localparam int TAG_OUT_BITS = 22;
    localparam int WAY_OUT_BITS = 2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_PROBE = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_LRU  = 2'd1,
        POL_LFU  = 2'd2,
        POL_NONE = 2'd3
    } t_policy;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic lookup;    // set read data is valid, compare and update
        logic flush_clr; // clear valid bits of the current flush set
        logic flush_start;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic flush_last;
        logic is_flush;
    } t_status;

endpackage

>>> src/sacd_datapath.sv
// set memories, tag compare, victim choice and result register
// depends on sacd_pkg
module sacd_datapath #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16,
    parameter int ADDR_BITS   = 32,
    parameter int STAMP_BITS  = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sacd_pkg::t_cmd                      i_cmd,
    output sacd_pkg::t_status                   o_status,
    input  logic [sacd_pkg::POLICY_BITS-1:0]    i_policy,
    input  logic [sacd_pkg::OP_BITS-1:0]        i_op,
    input  logic [ADDR_BITS-1:0]                i_address,
    input  logic                                i_write_accepted,
    output logic                                o_hit,
    output logic [sacd_pkg::WAY_OUT_BITS-1:0]   o_way_used,
    output logic                                o_fill_needed,
    output logic                                o_evicted_valid,
    output logic [sacd_pkg::TAG_OUT_BITS-1:0]   o_evicted_tag,
    output logic                                o_write_error
);
    import sacd_pkg::*;

    localparam int OB = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
    localparam int IB = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int SB = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TB = ADDR_BITS - OB - IB;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [TB-1:0]         tag;
        logic [STAMP_BITS-1:0] fill;
        logic [STAMP_BITS-1:0] used;
        logic [COUNT_BITS-1:0] cnt;
    } t_line;

    // one memory row per set holds all ways
    t_line [WAYS-1:0]         mem [SETS];
    t_line [WAYS-1:0]         r_rd;
    logic  [SETS-1:0][WAYS-1:0] r_valid;

    logic [OP_BITS-1:0]    r_op;
    logic [TB-1:0]         r_tag;
    logic [SB-1:0]         r_set;
    logic                  r_wacc;
    logic [STAMP_BITS-1:0] r_clock;
    logic [SB-1:0]         r_fset;

    logic [SB-1:0] set_in;
    logic [OB+IB-1:0] unused_hi;

    always_comb begin
        logic [IB:0] ix;
        ix = '0;
        if (IB > 0) ix[IB-1:0] = i_address[OB +: ((IB > 0) ? IB : 1)];
        unused_hi = '0;
        // reduce modulo sets when not a power of two
        if (ix >= (IB+1)'(SETS)) ix = ix - (IB+1)'(SETS);
        set_in = SB'(ix);
    end

    // read the set row
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_rd <= mem[set_in];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_tag  <= i_address[ADDR_BITS-1 -: TB];
            r_set  <= set_in;
            r_wacc <= i_write_accepted;
        end
    end

    // tag compare and victim choice
    logic [WAYS-1:0] vset;
    logic            hit;
    logic [WB-1:0]   hway, vway, inv_way, key_way;
    logic            any_inv;
    logic [STAMP_BITS-1:0] clk_nx;

    always_comb begin
        logic [STAMP_BITS-1:0] bk, k;
        vset = r_valid[r_set];
        hit = 1'b0; hway = '0; any_inv = 1'b0; inv_way = '0;
        for (int w = WAYS-1; w >= 0; w--) begin
            if (vset[w] && r_rd[w].tag == r_tag) begin
                hit = 1'b1; hway = WB'(w);
            end
            if (!vset[w]) begin
                any_inv = 1'b1; inv_way = WB'(w);
            end
        end
        bk = '0; key_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            unique case (t_policy'(i_policy))
                POL_FIFO: k = r_rd[w].fill;
                POL_LRU:  k = r_rd[w].used;
                POL_LFU:  k = STAMP_BITS'(r_rd[w].cnt);
                default:  k = '0;
            endcase
            if (w == 0 || k < bk) begin
                bk = k; key_way = WB'(w);
            end
        end
        if (any_inv) vway = inv_way;
        else if (t_policy'(i_policy) == POL_NONE) vway = '0;
        else vway = key_way;
        clk_nx = (r_clock != STAMP_MAX) ? r_clock + 1'b1 : r_clock;
    end

    logic do_upd, rej;
    assign rej    = (t_op'(r_op) == OP_WRITE) && !r_wacc;
    assign do_upd = i_cmd.lookup && !rej && (t_op'(r_op) == OP_READ
                    || t_op'(r_op) == OP_WRITE);

    t_line wr_line;
    logic [WB-1:0] wr_way;
    always_comb begin
        wr_way = hit ? hway : vway;
        wr_line = r_rd[wr_way];
        if (hit) begin
            wr_line.used = clk_nx;
            if (r_rd[hway].cnt != COUNT_MAX) wr_line.cnt = r_rd[hway].cnt + 1'b1;
        end else begin
            wr_line.tag  = r_tag;
            wr_line.fill = clk_nx;
            wr_line.used = clk_nx;
            wr_line.cnt  = COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_upd) mem[r_set][wr_way] <= wr_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_clock <= '0;
            r_fset  <= '0;
        end else begin
            if (do_upd) begin
                r_clock <= clk_nx;
                if (!hit) r_valid[r_set][wr_way] <= 1'b1;
            end
            if (i_cmd.flush_start) r_fset <= '0;
            if (i_cmd.flush_clr) begin
                r_valid[r_fset] <= '0;
                r_fset <= r_fset + 1'b1;
            end
        end
    end

    assign o_status.is_flush   = (t_op'(r_op) == OP_FLUSH);
    assign o_status.flush_last = (r_fset == SB'(SETS-1));

    // next result word
    logic                    n_hit, n_fill, n_ev, n_werr;
    logic [WAY_OUT_BITS-1:0] n_way;
    logic [TAG_OUT_BITS-1:0] n_etag;

    always_comb begin
        n_hit = 1'b0; n_way = '0; n_fill = 1'b0;
        n_ev = 1'b0; n_etag = '0; n_werr = 1'b0;
        priority if (t_op'(r_op) == OP_FLUSH) begin
        end else if (rej) begin
            n_werr = 1'b1;
        end else if (t_op'(r_op) == OP_PROBE) begin
            n_hit = hit;
            n_way = hit ? WAY_OUT_BITS'(32'(hway)) : '0;
        end else if (hit) begin
            n_hit = 1'b1;
            n_way = WAY_OUT_BITS'(32'(hway));
        end else begin
            n_way  = WAY_OUT_BITS'(32'(vway));
            n_fill = 1'b1;
            n_ev   = vset[vway];
            n_etag = vset[vway] ?
                TAG_OUT_BITS'(64'(r_rd[vway].tag) | 64'(unused_hi)) : '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            o_hit           <= n_hit;
            o_way_used      <= n_way;
            o_fill_needed   <= n_fill;
            o_evicted_valid <= n_ev;
            o_evicted_tag   <= n_etag;
            o_write_error   <= n_werr;
        end
    end

endmodule

>>> src/sacd_ctrl.sv
// controller: handshakes, lookup sequencing and flush sweep
// depends on sacd_pkg
module sacd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  sacd_pkg::t_status   i_status,
    output sacd_pkg::t_cmd      o_cmd
);
    import sacd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_FLUSH} t_state;
    t_state r_state;
    logic   r_ovalid;

    // next word taken only in the idle state, once the result slot is free or draining
    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;

    always_comb begin
        o_cmd = '0;
        o_cmd.capture     = i_valid && o_ready;
        o_cmd.lookup      = (r_state == S_LOOK && !i_status.is_flush)
                          || (r_state == S_FLUSH && i_status.flush_last);
        o_cmd.flush_start = (r_state == S_LOOK && i_status.is_flush);
        o_cmd.flush_clr   = (r_state == S_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd.lookup) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (o_cmd.capture) r_state <= S_LOOK;
                S_LOOK:  r_state <= i_status.is_flush ? S_FLUSH : S_IDLE;
                S_FLUSH: if (i_status.flush_last) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/set_assoc_cache_directory.sv
// top level of the set associative cache directory
// depends on sacd_pkg, sacd_ctrl, sacd_datapath
//
//  channel  | handshake            | word
//  input    | i_valid / o_ready    | i_op, i_address, i_write_accepted
//  result   | o_valid / i_ready    | o_hit .. o_write_error
//  config   | i_cfg_we             | i_cfg_data (replace policy)
//
// read, write and probe: set row read, then compare and write back
// flush clears one set row of valid bits per cycle
// a new word is taken only after the previous result is taken or leaving
// reset is synchronous; valid bits and access clock clear at once, no sweep
module set_assoc_cache_directory #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 16,
    parameter int ADDR_BITS   = 32,
    parameter int STAMP_BITS  = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sacd_pkg::POLICY_BITS-1:0]   i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sacd_pkg::OP_BITS-1:0]       i_op,
    input  logic [ADDR_BITS-1:0]               i_address,
    input  logic                               i_write_accepted,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_hit,
    output logic [sacd_pkg::WAY_OUT_BITS-1:0]  o_way_used,
    output logic                               o_fill_needed,
    output logic                               o_evicted_valid,
    output logic [sacd_pkg::TAG_OUT_BITS-1:0]  o_evicted_tag,
    output logic                               o_write_error
);
    import sacd_pkg::*;

    logic [POLICY_BITS-1:0] r_policy;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_policy <= POLICY_BITS'(POL_LRU);
        else if (i_cfg_we) r_policy <= i_cfg_data;
    end

    sacd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_status(status), .o_cmd(cmd)
    );

    sacd_datapath #(
        .SETS(SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES),
        .ADDR_BITS(ADDR_BITS), .STAMP_BITS(STAMP_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .i_policy(r_policy),
        .i_op, .i_address, .i_write_accepted,
        .o_hit, .o_way_used, .o_fill_needed, .o_evicted_valid,
        .o_evicted_tag, .o_write_error
    );

endmodule
